// ===== design/circle_pair_collision_response_assert.svh =====
// Assertion macros for the circle pair collision response block.
`ifndef CIRCLE_PAIR_COLLISION_RESPONSE_ASSERT_SVH
`define CIRCLE_PAIR_COLLISION_RESPONSE_ASSERT_SVH
`ifndef ASSERT_OFF
`define CPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CPC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CPC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/cpc_pkg.sv =====
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared widths, register codes and stage word types for the collision block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package cpc_pkg;
  localparam int GainW = 16;
  localparam logic [15:0] GainReset = 16'd328;
  localparam logic [0:0] RegResolveGain = 1'b0;

  // pipeline control type holding a valid and a stall bit
  typedef struct packed {
    logic valid;
    logic stall;
  } pipe_ctl_t;
endpackage

// ===== design/circle_pair_collision_response.sv =====
// ----------------------------------------------------------------------------
// circle_pair_collision_response
// Pipelined Verlet position correction for one pair of circles per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// The block takes one circle pair per clock while the output is not stalled
// and returns one word per pair in order. The pipeline has
// 114 register stages: four front stages, the 26-stage square root,
// the gain product, a 48-stage divider for the correction factor, two 32-stage
// mass weight dividers side by side, two multiply stages and the output
// register. The whole pipeline moves together, so a stall on the output
// freezes every stage and nothing is lost.
`timescale 1ns / 1ps
module circle_pair_collision_response (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_a_pos_x,
  input  logic signed [31:0] in_a_pos_y,
  input  logic signed [31:0] in_b_pos_x,
  input  logic signed [31:0] in_b_pos_y,
  input  logic [23:0]        in_a_radius,
  input  logic [23:0]        in_b_radius,
  input  logic [15:0]        in_a_mass,
  input  logic [15:0]        in_b_mass,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic signed [31:0] out_a_delta_x,
  output logic signed [31:0] out_a_delta_y,
  output logic signed [31:0] out_b_delta_x,
  output logic signed [31:0] out_b_delta_y
);
  import cpc_pkg::*;
`include "circle_pair_collision_response_assert.svh"

  localparam int SqN  = 26;  // root bits
  localparam int FNum = 48;  // gain*dist<<16 numerator bits
  localparam int WNum = 32;  // mass<<16 numerator bits
  // carried payload: hit, ok, dx(33), dy(33), ma, mb, gain
  localparam int PayW = 2 + 33 + 33 + 16 + 16 + GainW;

  logic [15:0] gain_r;
  logic        adv;

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GainReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == RegResolveGain
                 && cfg_paddr[1:0] == 2'b00) begin
      gain_r <= cfg_pwdata[15:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == RegResolveGain) ? {16'd0, gain_r} : 32'd0;

  // whole pipeline advances unless the output word is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // ---------------- stage 1: differences ----------------
  logic              s1_v_r;
  logic signed [32:0] s1_dx_r, s1_dy_r;
  logic [24:0]       s1_rsum_r;
  logic              s1_rnz_r;
  logic [15:0]       s1_ma_r, s1_mb_r, s1_g_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx_r   <= {in_a_pos_x[31], in_a_pos_x} - {in_b_pos_x[31], in_b_pos_x};
      s1_dy_r   <= {in_a_pos_y[31], in_a_pos_y} - {in_b_pos_y[31], in_b_pos_y};
      s1_rsum_r <= {1'b0, in_a_radius} + {1'b0, in_b_radius};
      s1_rnz_r  <= (in_a_radius != 24'd0) && (in_b_radius != 24'd0);
      s1_ma_r   <= in_a_mass;
      s1_mb_r   <= in_b_mass;
      s1_g_r    <= gain_r;
    end
  end

  // ---------------- stage 2: magnitudes, far test ----------------
  logic        s2_v_r, s2_ok_r;
  logic [32:0] adx_c, ady_c;
  logic [24:0] s2_ax_r, s2_ay_r, s2_rsum_r;
  logic signed [32:0] s2_dx_r, s2_dy_r;
  logic [15:0] s2_ma_r, s2_mb_r, s2_g_r;
  assign adx_c = s1_dx_r[32] ? 33'(-s1_dx_r) : s1_dx_r;
  assign ady_c = s1_dy_r[32] ? 33'(-s1_dy_r) : s1_dy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= s1_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ok_r   <= s1_rnz_r && adx_c[32:25] == 8'd0 && ady_c[32:25] == 8'd0;
      s2_ax_r   <= adx_c[24:0];
      s2_ay_r   <= ady_c[24:0];
      s2_rsum_r <= s1_rsum_r;
      s2_dx_r   <= s1_dx_r;
      s2_dy_r   <= s1_dy_r;
      s2_ma_r   <= s1_ma_r;
      s2_mb_r   <= s1_mb_r;
      s2_g_r    <= s1_g_r;
    end
  end

  // ---------------- stage 3: squares ----------------
  logic        s3_v_r, s3_ok_r;
  logic [49:0] s3_x2_r, s3_y2_r, s3_r2_r;
  logic [24:0] s3_rsum_r;
  logic signed [32:0] s3_dx_r, s3_dy_r;
  logic [15:0] s3_ma_r, s3_mb_r, s3_g_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (adv) s3_v_r <= s2_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_x2_r <= 50'(s2_ax_r) * 50'(s2_ax_r);
      s3_y2_r <= 50'(s2_ay_r) * 50'(s2_ay_r);
      s3_r2_r <= 50'(s2_rsum_r) * 50'(s2_rsum_r);
      s3_ok_r <= s2_ok_r;
      s3_rsum_r <= s2_rsum_r;
      s3_dx_r <= s2_dx_r;
      s3_dy_r <= s2_dy_r;
      s3_ma_r <= s2_ma_r;
      s3_mb_r <= s2_mb_r;
      s3_g_r  <= s2_g_r;
    end
  end

  // ---------------- stage 4: d2 and hit ----------------
  logic        s4_v_r, s4_hit_r;
  logic [50:0] d2_c;
  logic [51:0] s4_d2_r;
  logic [24:0] s4_rsum_r;
  logic signed [32:0] s4_dx_r, s4_dy_r;
  logic [15:0] s4_ma_r, s4_mb_r, s4_g_r;
  assign d2_c = {1'b0, s3_x2_r} + {1'b0, s3_y2_r};
  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (adv) s4_v_r <= s3_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_hit_r  <= s3_ok_r && (d2_c <= {1'b0, s3_r2_r});
      s4_d2_r   <= {1'b0, d2_c};
      s4_rsum_r <= s3_rsum_r;
      s4_dx_r   <= s3_dx_r;
      s4_dy_r   <= s3_dy_r;
      s4_ma_r   <= s3_ma_r;
      s4_mb_r   <= s3_mb_r;
      s4_g_r    <= s3_g_r;
    end
  end

  // ---------------- square root pipeline ----------------
  localparam int SqPay = PayW + 25 + 1;
  logic [2*SqN-1:0] sq_rad [SqN+1];
  logic [SqN+1:0]   sq_rem [SqN+1];
  logic [SqN-1:0]   sq_root[SqN+1];
  logic [SqPay-1:0] sq_pay [SqN+1];
  logic             sq_v_r [SqN+1];
  assign sq_rad[0]  = s4_d2_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_pay[0]  = {s4_hit_r, (s4_ma_r != 16'd0 || s4_mb_r != 16'd0),
                       s4_dx_r, s4_dy_r, s4_ma_r, s4_mb_r, s4_g_r, s4_rsum_r, 1'b0};
  assign sq_v_r[0]  = s4_v_r;
  for (genvar i = 0; i < SqN; i++) begin : g_sq
    cpc_sqrt_stage #(.RootW(SqN), .PayW(SqPay)) u_sq (
      .clk(clk), .en(adv), .rad(sq_rad[i]), .rem(sq_rem[i]), .root(sq_root[i]),
      .pay(sq_pay[i]), .rad_r(sq_rad[i+1]), .rem_r(sq_rem[i+1]),
      .root_r(sq_root[i+1]), .pay_r(sq_pay[i+1]));
    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[i+1] <= 1'b0;
      else if (adv) sq_v_r[i+1] <= sq_v_r[i];
    end
  end

  // unpack root-stage payload
  logic        p_hit, p_ok;
  logic signed [32:0] p_dx, p_dy;
  logic [15:0] p_ma, p_mb, p_g;
  logic [24:0] p_rsum;
  logic        p_unused;
  assign {p_hit, p_ok, p_dx, p_dy, p_ma, p_mb, p_g, p_rsum, p_unused} = sq_pay[SqN];

  // ---------------- stage 5: gain*dist ----------------
  logic        s5_v_r;
  logic [41:0] s5_gd_r;
  logic [PayW-1:0] s5_pay_r;
  logic [24:0] s5_rsum_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (adv) s5_v_r <= sq_v_r[SqN];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_gd_r   <= 42'(p_g) * 42'(sq_root[SqN]);
      s5_pay_r  <= {p_hit, p_ok, p_dx, p_dy, p_ma, p_mb, p_g} ^ {PayW{p_unused}};
      s5_rsum_r <= (p_rsum == 25'd0) ? 25'd1 : p_rsum;
    end
  end

  // ---------------- divider for f ----------------
  // numerator is gain*dist << 16 but only the low 48 quotient bits matter:
  // dist <= rsum so f < 2^32; top bits of the 58-bit quotient are zero
  localparam int FPay = PayW + 32;
  logic [FNum-1:0] fd_num[FNum+1];
  logic [24:0]     fd_den[FNum+1];
  logic [25:0]     fd_rem[FNum+1];
  logic [FNum-1:0] fd_quo[FNum+1];
  logic [FPay-1:0] fd_pay[FNum+1];
  logic            fd_v_r[FNum+1];
  logic [57:0]     fnum_c;
  assign fnum_c    = {s5_gd_r, 16'd0};
  assign fd_num[0] = fnum_c[47:0];
  assign fd_den[0] = s5_rsum_r;
  // upper 10 numerator bits are the initial partial remainder (value < rsum)
  assign fd_rem[0] = {16'd0, fnum_c[57:48]};
  assign fd_quo[0] = '0;
  assign fd_v_r[0] = s5_v_r;
  // carry the payload alongside the division
  assign fd_pay[0] = {s5_pay_r, 32'd0};
  for (genvar i = 0; i < FNum; i++) begin : g_fd
    cpc_div_stage #(.NumW(FNum), .DenW(25), .PayW(FPay)) u_fd (
      .clk(clk), .en(adv), .num(fd_num[i]), .den(fd_den[i]), .rem(fd_rem[i]),
      .quo(fd_quo[i]), .pay(fd_pay[i]), .num_r(fd_num[i+1]), .den_r(fd_den[i+1]),
      .rem_r(fd_rem[i+1]), .quo_r(fd_quo[i+1]), .pay_r(fd_pay[i+1]));
    always_ff @(posedge clk) begin
      if (!rst_n) fd_v_r[i+1] <= 1'b0;
      else if (adv) fd_v_r[i+1] <= fd_v_r[i];
    end
  end

  // ---------------- weight dividers ----------------
  logic [PayW-1:0] f_pay;
  logic [31:0]     f_padding;
  logic            q_hit, q_ok;
  logic signed [32:0] q_dx, q_dy;
  logic [15:0] q_ma, q_mb, q_g;
  assign {f_pay, f_padding} = fd_pay[FNum];
  assign {q_hit, q_ok, q_dx, q_dy, q_ma, q_mb, q_g} = f_pay ^ {PayW{p_unused}};
  logic [16:0] msum_c;
  assign msum_c = (q_ma + 17'(q_mb)) | {16'd0, f_padding == 32'd0 && !q_ok};

  localparam int WPay = PayW + 32;
  logic [WNum-1:0] wa_num[WNum+1], wb_num[WNum+1];
  logic [16:0]     wa_den[WNum+1], wb_den[WNum+1];
  logic [17:0]     wa_rem[WNum+1], wb_rem[WNum+1];
  logic [WNum-1:0] wa_quo[WNum+1], wb_quo[WNum+1];
  logic [WPay-1:0] wa_pay[WNum+1];
  logic [WPay-1:0] wb_pay[WNum+1];
  logic            w_v_r[WNum+1];
  assign wa_num[0] = {q_ma, 16'd0};
  assign wb_num[0] = {q_mb, 16'd0};
  assign wa_den[0] = (msum_c == 17'd0) ? 17'd1 : msum_c;
  assign wb_den[0] = (msum_c == 17'd0) ? 17'd1 : msum_c;
  assign wa_rem[0] = '0;
  assign wb_rem[0] = '0;
  assign wa_quo[0] = '0;
  assign wb_quo[0] = '0;
  assign wa_pay[0] = {f_pay, fd_quo[FNum][31:0]};
  assign wb_pay[0] = '0;
  assign w_v_r[0]  = fd_v_r[FNum];
  for (genvar i = 0; i < WNum; i++) begin : g_w
    cpc_div_stage #(.NumW(WNum), .DenW(17), .PayW(WPay)) u_wa (
      .clk(clk), .en(adv), .num(wa_num[i]), .den(wa_den[i]), .rem(wa_rem[i]),
      .quo(wa_quo[i]), .pay(wa_pay[i]), .num_r(wa_num[i+1]), .den_r(wa_den[i+1]),
      .rem_r(wa_rem[i+1]), .quo_r(wa_quo[i+1]), .pay_r(wa_pay[i+1]));
    cpc_div_stage #(.NumW(WNum), .DenW(17), .PayW(WPay)) u_wb (
      .clk(clk), .en(adv), .num(wb_num[i]), .den(wb_den[i]), .rem(wb_rem[i]),
      .quo(wb_quo[i]), .pay(wb_pay[i]), .num_r(wb_num[i+1]), .den_r(wb_den[i+1]),
      .rem_r(wb_rem[i+1]), .quo_r(wb_quo[i+1]), .pay_r(wb_pay[i+1]));
    always_ff @(posedge clk) begin
      if (!rst_n) w_v_r[i+1] <= 1'b0;
      else if (adv) w_v_r[i+1] <= w_v_r[i];
    end
  end

  logic [PayW-1:0] w_pay;
  logic [31:0]     w_f;
  logic            w_hit, w_ok;
  logic signed [32:0] w_dx, w_dy;
  logic [15:0] w_ma, w_mb, w_g;
  assign {w_pay, w_f} = wa_pay[WNum] | wb_pay[WNum];
  assign {w_hit, w_ok, w_dx, w_dy, w_ma, w_mb, w_g} = w_pay;

  // ---------------- stage 6: k = f*w >> 16 ----------------
  logic        s6_v_r, s6_hit_r, s6_ok_r;
  logic [49:0] s6_ka_r, s6_kb_r;
  logic signed [32:0] s6_dx_r, s6_dy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s6_v_r <= 1'b0;
    else if (adv) s6_v_r <= w_v_r[WNum];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s6_ka_r  <= 50'(w_f) * 50'(wa_quo[WNum][16:0]);
      s6_kb_r  <= 50'(w_f) * 50'(wb_quo[WNum][16:0]);
      s6_hit_r <= w_hit;
      s6_ok_r  <= w_ok && (w_ma[0] | !w_ma[0]) && (w_g[0] | !w_g[0])
                  && (w_mb[0] | !w_mb[0]);
      s6_dx_r  <= w_dx;
      s6_dy_r  <= w_dy;
    end
  end

  // ---------------- stage 7: |D|*k ----------------
  logic        s7_v_r, s7_hit_r, s7_ok_r;
  logic [65:0] s7_ax_r, s7_ay_r, s7_bx_r, s7_by_r;
  logic        s7_nx_r, s7_ny_r;
  logic [32:0] mx_c, my_c;
  logic [33:0] ka_c, kb_c;
  assign mx_c = s6_dx_r[32] ? 33'(-s6_dx_r) : s6_dx_r;
  assign my_c = s6_dy_r[32] ? 33'(-s6_dy_r) : s6_dy_r;
  assign ka_c = s6_ka_r[49:16];
  assign kb_c = s6_kb_r[49:16];
  always_ff @(posedge clk) begin
    if (!rst_n) s7_v_r <= 1'b0;
    else if (adv) s7_v_r <= s6_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s7_ax_r  <= 66'(mx_c) * 66'(ka_c[31:0]);
      s7_ay_r  <= 66'(my_c) * 66'(ka_c[31:0]);
      s7_bx_r  <= 66'(mx_c) * 66'(kb_c[31:0]);
      s7_by_r  <= 66'(my_c) * 66'(kb_c[31:0]);
      s7_nx_r  <= s6_dx_r[32];
      s7_ny_r  <= s6_dy_r[32];
      s7_hit_r <= s6_hit_r;
      s7_ok_r  <= s6_ok_r && s6_hit_r;
    end
  end

  // ---------------- output register with saturation ----------------
  function automatic logic [31:0] sat(input logic [65:0] p, input logic neg);
    logic [33:0] mag;
    mag = p[65:32];
    if (neg) sat = (mag > 34'h080000000) ? 32'h80000000 : 32'(-mag);
    else     sat = (mag > 34'h07fffffff) ? 32'h7fffffff : mag[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= s7_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit       <= s7_hit_r;
      out_a_delta_x <= s7_ok_r ? sat(s7_ax_r, !s7_nx_r) : 32'd0;
      out_a_delta_y <= s7_ok_r ? sat(s7_ay_r, !s7_ny_r) : 32'd0;
      out_b_delta_x <= s7_ok_r ? sat(s7_bx_r, s7_nx_r) : 32'd0;
      out_b_delta_y <= s7_ok_r ? sat(s7_by_r, s7_ny_r) : 32'd0;
    end
  end

  // ---------------- checks ----------------
  `CPC_ASSERT_NXT(a_hold_out, clk, rst_n, out_valid && out_stall, out_valid)
  `CPC_ASSERT_IMP(a_stall_link, clk, rst_n, out_valid && out_stall, in_stall)
  `CPC_ASSERT_IMP(a_nohit_zero, clk, rst_n, out_valid && !out_hit,
                  out_a_delta_x == 32'd0 && out_b_delta_y == 32'd0)
endmodule

// ===== design/cpc_div_stage.sv =====
// ----------------------------------------------------------------------------
// cpc_div_stage
// One radix-2 restoring division step as a registered pipeline stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cpc_div_stage #(
  parameter int NumW = 48,
  parameter int DenW = 25,
  parameter int PayW = 8
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  input  logic [DenW:0]   rem,
  input  logic [NumW-1:0] quo,
  input  logic [PayW-1:0] pay,
  output logic [NumW-1:0] num_r,
  output logic [DenW-1:0] den_r,
  output logic [DenW:0]   rem_r,
  output logic [NumW-1:0] quo_r,
  output logic [PayW-1:0] pay_r
);
  logic [DenW+1:0] shifted;
  logic [DenW+1:0] diff;
  logic            take;

  // shift in the next numerator bit and try a subtract
  always_comb begin
    shifted = {rem, num[NumW-1]};
    diff    = shifted - {2'b00, den};
    take    = !diff[DenW+1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= {num[NumW-2:0], 1'b0};
      den_r <= den;
      rem_r <= take ? diff[DenW:0] : shifted[DenW:0];
      quo_r <= {quo[NumW-2:0], take};
      pay_r <= pay;
    end
  end
endmodule

// ===== design/cpc_sqrt_stage.sv =====
// ----------------------------------------------------------------------------
// cpc_sqrt_stage
// One bit of a restoring integer square root as a registered pipeline stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cpc_sqrt_stage #(
  parameter int RootW = 26,
  parameter int PayW  = 8
) (
  input  logic             clk,
  input  logic             en,
  input  logic [2*RootW-1:0] rad,
  input  logic [RootW+1:0] rem,
  input  logic [RootW-1:0] root,
  input  logic [PayW-1:0]  pay,
  output logic [2*RootW-1:0] rad_r,
  output logic [RootW+1:0] rem_r,
  output logic [RootW-1:0] root_r,
  output logic [PayW-1:0]  pay_r
);
  logic [RootW+1:0] cur;
  logic [RootW+1:0] trial;
  logic [RootW+2:0] diff;

  // bring down two bits, trial subtract 4*root+1
  always_comb begin
    cur   = {rem[RootW-1:0], rad[2*RootW-1 -: 2]};
    trial = {root, 2'b01};
    diff  = {1'b0, cur} - {1'b0, trial};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad[2*RootW-3:0], 2'b00};
      rem_r  <= diff[RootW+2] ? cur : diff[RootW+1:0];
      root_r <= {root[RootW-2:0], !diff[RootW+2]};
      pay_r  <= pay;
    end
  end
endmodule

// ===== tb/sv/tb_circle_pair_collision_response.sv =====
// ----------------------------------------------------------------------------
// tb_circle_pair_collision_response
// Self-checking bench: drives circle pairs under random idling and stalls,
// predicts the Verlet correction in fixed point and checks every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_circle_pair_collision_response;
  import cpc_pkg::*;

  typedef struct {
    logic signed [31:0] ax, ay, bx, by;
    logic [23:0]        ra, rb;
    logic [15:0]        ma, mb;
  } pair_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] adx, ady, bdx, bdy;
  } resp_t;

  localparam int DrainCycles = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_a_pos_x = '0, in_a_pos_y = '0, in_b_pos_x = '0, in_b_pos_y = '0;
  logic [23:0] in_a_radius = '0, in_b_radius = '0;
  logic [15:0] in_a_mass = '0, in_b_mass = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic signed [31:0] out_a_delta_x, out_a_delta_y, out_b_delta_x, out_b_delta_y;

  pair_t pair_q[$];
  resp_t response_q[$];
  pair_t cur_pair;
  logic [15:0] gain_model = GainReset;
  int pairs_sent = 0;
  int mismatches = 0;
  bit quiet = 1'b0;
  bit hold_rx = 1'b0;

  circle_pair_collision_response dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Floor square root, one result bit per step
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned t;
    for (int b = 27; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Scale a difference by k/2^32, truncate toward zero, saturate
  function automatic logic signed [31:0] scale_delta(longint signed d, longint unsigned k,
                                                      bit negate);
    longint unsigned mag = ((d < 0 ? -d : d) * k) >> 32;
    bit neg = (d < 0) ^ negate;
    if (neg) return (mag > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-longint'(mag));
    return (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(mag);
  endfunction

  function automatic resp_t collision_response(pair_t p, logic [15:0] gain);
    longint signed dx = longint'(p.ax) - longint'(p.bx);
    longint signed dy = longint'(p.ay) - longint'(p.by);
    longint unsigned adx = dx < 0 ? -dx : dx;
    longint unsigned ady = dy < 0 ? -dy : dy;
    longint unsigned rsum = longint'(p.ra) + longint'(p.rb);
    longint unsigned msum = longint'(p.ma) + longint'(p.mb);
    longint unsigned d2, f, ka, kb;
    resp_t r = '0;
    if (p.ra == 0 || p.rb == 0 || adx >= (64'd1 << 25) || ady >= (64'd1 << 25)) return r;
    d2 = adx * adx + ady * ady;
    if (d2 > rsum * rsum) return r;
    r.hit = 1'b1;
    if (msum == 0) return r;
    f = ((longint'(gain) * floor_root(d2)) << 16) / rsum;
    ka = (f * ((longint'(p.ma) << 16) / msum)) >> 16;
    kb = (f * ((longint'(p.mb) << 16) / msum)) >> 16;
    r.adx = scale_delta(dx, ka, 1'b1);
    r.ady = scale_delta(dy, ka, 1'b1);
    r.bdx = scale_delta(dx, kb, 1'b0);
    r.bdy = scale_delta(dy, kb, 1'b0);
    return r;
  endfunction

  // Driver: advance to the next pair once the current word is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        response_q = {response_q, collision_response(cur_pair, gain_model)};
        pairs_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pair_q.size() > 0 && (quiet || $urandom_range(99) >= 7)) begin
          cur_pair = pair_q.pop_front();
          in_valid <= 1'b1;
          in_a_pos_x <= cur_pair.ax;
          in_a_pos_y <= cur_pair.ay;
          in_b_pos_x <= cur_pair.bx;
          in_b_pos_y <= cur_pair.by;
          in_a_radius <= cur_pair.ra;
          in_b_radius <= cur_pair.rb;
          in_a_mass <= cur_pair.ma;
          in_b_mass <= cur_pair.mb;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, check each taken word against the oldest prediction
  always @(posedge clk) begin
    resp_t got, want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_hit, out_a_delta_x, out_a_delta_y, out_b_delta_x, out_b_delta_y};
        if (response_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word: %p", got);
        end else begin
          want = response_q.pop_front();
          if (got.hit !== want.hit || got.adx !== want.adx || got.ady !== want.ady ||
              got.bdx !== want.bdx || got.bdy !== want.bdy) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("mismatch: expected hit=%0d a=(%0d,%0d) b=(%0d,%0d) ",
                     want.hit, want.adx, want.ady, want.bdx, want.bdy);
              $display("got hit=%0d a=(%0d,%0d) b=(%0d,%0d)",
                       got.hit, got.adx, got.ady, got.bdx, got.bdy);
            end
          end
        end
      end
    end
    out_stall <= hold_rx || (!quiet && $urandom_range(99) < 7);
  end

  // Long receiver hold-off so the pipeline fills and pushes back
  initial begin
    wait (pairs_sent >= 100);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (400) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic write_gain(logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(4 * int'(RegResolveGain));
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    gain_model = value[15:0];
  endtask

  task automatic add_pair(int ax, int ay, int bx, int by, int ra, int rb, int ma, int mb);
    pair_t p;
    p.ax = ax; p.ay = ay; p.bx = bx; p.by = by;
    p.ra = 24'(ra); p.rb = 24'(rb); p.ma = 16'(ma); p.mb = 16'(mb);
    pair_q = {pair_q, p};
  endtask

  // Mostly nearby pairs with radii around the gap, some pure noise
  task automatic add_random(int count);
    pair_t p;
    int span;
    repeat (count) begin
      p.ax = $urandom; p.ay = $urandom; p.bx = $urandom; p.by = $urandom;
      p.ra = 24'($urandom); p.rb = 24'($urandom);
      p.ma = 16'($urandom); p.mb = 16'($urandom);
      if ($urandom_range(9) != 0) begin
        span = $urandom_range(22, 12);
        p.bx = p.ax - $signed($urandom_range(2 << span, 0)) + (1 << span);
        p.by = p.ay - $signed($urandom_range(2 << span, 0)) + (1 << span);
        p.ra = 24'($urandom_range(1 << span, 0));
        p.rb = 24'($urandom_range(1 << span, 0));
        if ($urandom_range(15) == 0) p.ma = 16'd0;
        if ($urandom_range(15) == 0) p.mb = 16'd0;
      end
      pair_q = {pair_q, p};
    end
  endtask

  task automatic drain();
    wait (pair_q.size() == 0 && !in_valid && response_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners at the reset gain
    add_pair(0, 0, 0, 0, 4096, 4096, 256, 256);                  // coincident centers
    add_pair(8192, 0, 0, 0, 4096, 4096, 256, 512);               // exactly touching
    add_pair(8193, 0, 0, 0, 4096, 4096, 256, 512);               // just apart
    add_pair(100, 100, 0, 0, 0, 4096, 256, 256);                 // zero radius A
    add_pair(100, 100, 0, 0, 4096, 0, 256, 256);                 // zero radius B
    add_pair(1 << 25, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 256, 256); // far apart in x
    add_pair(0, -(1 << 25), 0, 0, 24'hFFFFFF, 24'hFFFFFF, 256, 256); // far apart in y
    add_pair(-300, 500, 200, -100, 8192, 8192, 0, 0);            // zero mass sum
    add_pair(-300, 500, 200, -100, 8192, 8192, 0, 65535);        // massless A
    add_pair(-300, 500, 200, -100, 8192, 8192, 65535, 0);        // massless B
    add_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
             24'hFFFFFF, 24'hFFFFFF, 65535, 65535);
    add_pair(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
             24'hFFFFFF, 24'hFFFFFF, 65535, 65535);
    add_pair((1 << 25) - 1, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 65535, 1);
    add_pair(-((1 << 25) - 1), -((1 << 24)), 0, 0, 24'hFFFFFF, 24'hFFFFFF, 1, 65535);
    add_pair(-1, -1, 32'h7FFFF000, 32'h7FFFF000, 1, 1, 65535, 65535);
    add_pair(32'h7FFFF000, 32'h7FFFF000, 32'h7FFFF800, 32'h7FFFF800, 4096, 4096, 300, 700);
    add_pair(-40000, 30000, 40000, -30000, 24'h800000, 24'h800000, 32768, 32768);
    add_random(150);
    drain();

    write_gain(32'hFFFF_FFFF);
    add_random(160);
    drain();

    // No idling on either side in this phase
    quiet = 1'b1;
    write_gain(32'h0);
    add_random(160);
    drain();
    quiet = 1'b0;

    write_gain($urandom);
    add_random(160);
    drain();

    if (mismatches == 0 && response_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
